/* design/cma_pkg.sv */
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants for the centered moving average unit: item
// structs for the sample and result channels and the register index codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cma_pkg;

	// Sample width of the fixed-point stream.
	localparam int SAMPLE_BITS = 24;

	// Widest configuration register (half_width).
	localparam int CFG_BITS = 6;

	// Default largest half window.
	localparam int MAX_HALF_DEF = 32;

	// Width of the per-stream sample and result counters.
	localparam int CNT_BITS = 32;

	// Configuration register indexes.
	typedef enum logic {
		CFG_HALF_WIDTH = 1'b0,
		CFG_PAD_EDGES  = 1'b1
	} cfg_index_t;

	// One input item.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last_in;
	} cma_in_t;

	// One result item.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] average;
		logic                          is_pad;
		logic                          last_out;
	} cma_out_t;

endpackage

`default_nettype wire

/* design/centered_moving_average_unit.sv */
// ----------------------------------------------------------------------------
// centered_moving_average_unit
// Centered boxcar moving average over a stream of signed samples, with edge
// trimming or zero padding. Prefix sums live in one synchronous memory.
// ----------------------------------------------------------------------------
//
//   channel   signals                          carries
//   --------  -------------------------------  ------------------------------
//   sample    src_valid, src_ready, src_item   sample, last_in
//   result    res_valid, res_ready, res_item   average, is_pad, last_out
//   config    cfg_we, cfg_index, cfg_wdata     half_width, pad_edges
//
// One sample is taken per cycle while results are taken as they appear.
// A sample that closes a stream in pad mode holds the sample channel until its
// trailing zeros are issued, up to MAX_HALF+1 results in all.
// A result passes from its sample through memory read, window sum, reciprocal
// multiply, remainder multiply and correction into the output register.
// Reset clears the counters and pipeline valids; no memory clearing pass.
// A stalled result channel with stage 4 busy freezes pipeline and sample channel.
// ----------------------------------------------------------------------------
`default_nettype none

module centered_moving_average_unit
	import cma_pkg::*;
#(
	parameter int MAX_HALF = MAX_HALF_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       src_valid,
	output logic            src_ready,
	input  wire cma_in_t    src_item,
	output logic            res_valid,
	input  wire logic       res_ready,
	output cma_out_t        res_item,
	input  wire logic       cfg_we,
	input  wire cfg_index_t cfg_index,
	input  wire logic [CFG_BITS-1:0] cfg_wdata
);

	localparam int W_MAX = 2 * MAX_HALF + 1;
	localparam int WW    = $clog2(W_MAX + 1);
	localparam int HW    = $clog2(MAX_HALF + 1);
	localparam int DEPTH = 1 << WW;
	localparam int SUM_W = SAMPLE_BITS + WW;
	localparam int ABS_W = SUM_W - 1;
	localparam int PROD_W = 2 * ABS_W + 1;
	localparam int TW    = $clog2(MAX_HALF + 2);
	localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_PAD,
		RES_MEAN
	} res_kind_t;

	// Configuration registers.
	logic [CFG_BITS-1:0] half_width_q;
	logic                pad_edges_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= CFG_BITS'(1);
			pad_edges_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HALF_WIDTH: half_width_q <= cfg_wdata;
				CFG_PAD_EDGES:  pad_edges_q  <= cfg_wdata[0];
				default:        ;
			endcase
		end
	end

	// Clamped half width and window length.
	logic [HW-1:0] h_c;
	logic [WW-1:0] w_c;

	assign h_c = (half_width_q > CFG_BITS'(MAX_HALF)) ? HW'(MAX_HALF) : half_width_q[HW-1:0];
	assign w_c = {h_c, 1'b1};

	// Reciprocal table: floor(2^ABS_W / w) for every half width.
	logic [ABS_W:0] recip_tab [MAX_HALF+1];

	for (genvar g = 0; g <= MAX_HALF; g++) begin : g_rcp
		localparam longint unsigned RecipVal = (64'd1 << ABS_W) / longint'(2 * g + 1);
		assign recip_tab[g] = RecipVal[ABS_W:0];
	end

	// Stream state.
	logic [CNT_BITS-1:0] seen_q;
	logic [CNT_BITS-1:0] sent_q;
	logic [SUM_W-1:0]    psum_q;
	logic [WW-1:0]       wptr_q;

	// Pipeline control.
	logic adv;
	logic accept;

	assign src_ready = adv;
	assign accept    = src_valid && adv;

	// Per-item plan: counters decide the results before any data is read.
	logic [CNT_BITS-1:0] n_next;
	logic [CNT_BITS-1:0] sent_next;
	logic [CNT_BITS-1:0] rem;
	logic [TW-1:0]       room;
	logic [TW-1:0]       tail_c;
	res_kind_t           kind_c;
	logic                n_main;
	logic                sub_c;
	logic [SUM_W-1:0]    psum_next;

	always_comb begin
		n_next = (seen_q == CNT_MAX) ? seen_q : seen_q + CNT_BITS'(1);
		priority if (pad_edges_q && n_next <= CNT_BITS'(h_c)) begin
			kind_c = RES_PAD;
		end else if (n_next >= CNT_BITS'(w_c)) begin
			kind_c = RES_MEAN;
		end else begin
			kind_c = RES_NONE;
		end
		n_main    = (kind_c != RES_NONE);
		sent_next = (n_main && sent_q != CNT_MAX) ? sent_q + CNT_BITS'(1) : sent_q;
		rem       = (n_next > sent_next) ? n_next - sent_next : '0;
		room      = TW'(MAX_HALF + 1) - TW'(n_main);
		if (src_item.last_in && pad_edges_q) begin
			tail_c = (rem > CNT_BITS'(room)) ? room : rem[TW-1:0];
		end else begin
			tail_c = '0;
		end
		sub_c     = (n_next > CNT_BITS'(w_c));
		psum_next = psum_q + {{WW{src_item.sample[SAMPLE_BITS-1]}}, src_item.sample};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			sent_q <= '0;
			psum_q <= '0;
			wptr_q <= '0;
		end else if (accept) begin
			wptr_q <= wptr_q + WW'(1);
			if (src_item.last_in) begin
				seen_q <= '0;
				sent_q <= '0;
				psum_q <= '0;
			end else begin
				seen_q <= n_next;
				sent_q <= sent_next;
				psum_q <= psum_next;
			end
		end
	end

	// Prefix-sum memory: write the new prefix, read the one w samples back.
	logic [SUM_W-1:0] psum_mem [DEPTH];
	logic [SUM_W-1:0] rd_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= psum_mem[wptr_q - w_c];
			psum_mem[wptr_q] <= psum_next;
		end
	end

	// Stage 1: window sum and magnitude.
	logic             vld_s1, last_s1, sub_s1;
	res_kind_t        kind_s1;
	logic [TW-1:0]    tail_s1;
	logic [HW-1:0]    h_s1;
	logic [SUM_W-1:0] psum_s1;
	logic [SUM_W-1:0] win;
	logic [SUM_W-1:0] win_mag;
	logic             neg_c;

	assign win     = psum_s1 - (sub_s1 ? rd_s1 : '0);
	assign neg_c   = win[SUM_W-1];
	assign win_mag = neg_c ? (SUM_W'(0) - win) : win;

	// Stage 2: multiply by the reciprocal.
	logic              vld_s2, last_s2, neg_s2;
	res_kind_t         kind_s2;
	logic [TW-1:0]     tail_s2;
	logic [HW-1:0]     h_s2;
	logic [ABS_W-1:0]  abs_s2;
	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(abs_s2) * PROD_W'(recip_tab[h_s2]);

	// Stage 3: estimated quotient times w.
	logic                vld_s3, last_s3, neg_s3;
	res_kind_t           kind_s3;
	logic [TW-1:0]       tail_s3;
	logic [HW-1:0]       h_s3;
	logic [ABS_W-1:0]    abs_s3, q0_s3;
	logic [ABS_W+WW-1:0] qw_full;

	assign qw_full = (ABS_W + WW)'(q0_s3) * (ABS_W + WW)'({h_s3, 1'b1});

	// Stage 4: one correction step, sign, and result issue.
	logic             vld_s4, last_s4, neg_s4;
	res_kind_t        kind_s4;
	logic [TW-1:0]    tail_s4;
	logic [HW-1:0]    h_s4;
	logic [ABS_W-1:0] abs_s4, q0_s4, qw_s4;
	logic [ABS_W-1:0] rmd;
	logic [ABS_W-1:0] q_fix;
	logic [ABS_W-1:0] mean_c;
	logic             main_done_q;

	assign rmd    = abs_s4 - qw_s4;
	assign q_fix  = (rmd >= ABS_W'({h_s4, 1'b1})) ? q0_s4 + ABS_W'(1) : q0_s4;
	assign mean_c = neg_s4 ? (ABS_W'(0) - q_fix) : q_fix;

	logic has_main, has_tail, out_free, emit_main, emit_tail;

	assign has_main  = vld_s4 && (kind_s4 != RES_NONE) && !main_done_q;
	assign has_tail  = vld_s4 && (tail_s4 != '0);
	assign out_free  = !res_valid || res_ready;
	assign emit_main = out_free && has_main;
	assign emit_tail = out_free && !has_main && has_tail;
	assign adv = !vld_s4 || (!has_main && tail_s4 == '0) ||
		(out_free && ((has_main && tail_s4 == '0) || (!has_main && tail_s4 == TW'(1))));

	// Pipeline valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			main_done_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= accept;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			main_done_q <= 1'b0;
		end else if (emit_main) begin
			main_done_q <= 1'b1;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind_c;
			tail_s1 <= tail_c;
			last_s1 <= src_item.last_in;
			h_s1    <= h_c;
			sub_s1  <= sub_c;
			psum_s1 <= psum_next;

			kind_s2 <= kind_s1;
			tail_s2 <= tail_s1;
			last_s2 <= last_s1;
			h_s2    <= h_s1;
			neg_s2  <= neg_c;
			abs_s2  <= win_mag[ABS_W-1:0];

			kind_s3 <= kind_s2;
			tail_s3 <= tail_s2;
			last_s3 <= last_s2;
			h_s3    <= h_s2;
			neg_s3  <= neg_s2;
			abs_s3  <= abs_s2;
			q0_s3   <= prod[2*ABS_W-1:ABS_W];

			kind_s4 <= kind_s3;
			tail_s4 <= tail_s3;
			last_s4 <= last_s3;
			h_s4    <= h_s3;
			neg_s4  <= neg_s3;
			abs_s4  <= abs_s3;
			q0_s4   <= q0_s3;
			qw_s4   <= qw_full[ABS_W-1:0];
		end else if (emit_tail) begin
			tail_s4 <= tail_s4 - TW'(1);
		end
	end

	// Output register.
	logic     res_valid_q;
	cma_out_t res_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_main || emit_tail) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_main) begin
			res_item_q.average  <= (kind_s4 == RES_MEAN) ? mean_c[SAMPLE_BITS-1:0] : '0;
			res_item_q.is_pad   <= (kind_s4 == RES_PAD);
			res_item_q.last_out <= last_s4 && (tail_s4 == '0);
		end else if (emit_tail) begin
			res_item_q.average  <= '0;
			res_item_q.is_pad   <= 1'b1;
			res_item_q.last_out <= (tail_s4 == TW'(1));
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

`default_nettype wire

/* design/cma_checker.sv */
// ----------------------------------------------------------------------------
// cma_checker
// Port-level checks for the centered moving average unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_checker
	import cma_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     src_valid,
	input wire logic     src_ready,
	input wire logic     res_valid,
	input wire logic     res_ready,
	input wire cma_out_t res_item
);

	// A result that is not taken stays offered, unchanged.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result item dropped or changed while stalled");

	// An edge zero always carries a zero average.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.is_pad |-> res_item.average == '0)
		else $error("pad result with nonzero average");

	// No result is offered on the first edge after reset ends.
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !res_valid)
		else $error("result offered straight out of reset");

	// The sample channel is only held back while a result is being produced.
	a_blocked_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_ready |=> res_valid)
		else $error("sample channel blocked with no result on offer");

endmodule

bind centered_moving_average_unit cma_checker u_cma_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_ready (src_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_item  (res_item)
);

`default_nettype wire
